// ===== hw/rtl/decimating_discharge_logger_assert.svh =====
// Assertion macros for the decimating discharge logger.
// Included by the top level; no other dependencies.
`ifndef DECIMATING_DISCHARGE_LOGGER_ASSERT_SVH
`define DECIMATING_DISCHARGE_LOGGER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define DDL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Property whose consequent must hold in the cycle after its antecedent.
`define DDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define DDL_ASSERT(label, clk, rst_n, prop)
`define DDL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/ddl_pkg.sv =====
// Shared types and constants of the decimating discharge logger.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ddl_pkg;

	localparam int LOG_DEPTH_DEF = 256;
	localparam logic [15:0] INTERVAL_RESET = 16'd60;
	localparam logic [15:0] INTERVAL_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_TICK   = 2'd1,
		OP_CANCEL = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_REJECTED   = 2'd1,
		ST_NOT_STORED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OUTC_NONE   = 3'd0,
		OUTC_RUN    = 3'd1,
		OUTC_DONE   = 3'd2,
		OUTC_ABORT  = 3'd3,
		OUTC_CANCEL = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CMP,
		S_COMPACT,
		S_APPEND,
		S_FINISH
	} state_t;

	// One logged point.
	typedef struct packed {
		logic [15:0]        heap_kb;
		logic               radio;
		logic signed [15:0] ma;
		logic [9:0]         soc_x10;
		logic signed [15:0] mv;
		logic [31:0]        time_s;
	} entry_t;

	typedef struct packed {
		op_t                opcode;
		logic [31:0]        now_s;
		logic signed [15:0] cell_mv;
		logic [9:0]         soc_x10;
		logic signed [15:0] cell_ma;
		logic               radio_on;
		logic [15:0]        heap_kb;
		logic               reading_valid;
		logic               ext_supply;
		logic               level_critical;
		logic               charging;
		logic [7:0]         read_index;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic        running;
		outcome_t    run_outcome;
		logic [8:0]  stored_count;
		logic [15:0] current_interval_s;
		logic        appended;
		entry_t      entry;
	} result_t;

endpackage

// ===== hw/rtl/ddl_store.sv =====
// Log store of the decimating discharge logger: one write port, one registered read port.
// Depends on ddl_pkg for the entry type.
`timescale 1ns / 1ps

module ddl_store #(
	parameter int LOG_DEPTH = ddl_pkg::LOG_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(LOG_DEPTH)-1:0] wr_addr,
	input  ddl_pkg::entry_t              wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(LOG_DEPTH)-1:0] rd_addr,
	output ddl_pkg::entry_t              rd_data
);
	import ddl_pkg::*;

	entry_t mem [LOG_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/ddl_ctrl.sv =====
// Sequencer and run state of the decimating discharge logger, with the shared time subtractor.
// Depends on ddl_pkg; drives the ports of ddl_store.
`timescale 1ns / 1ps

module ddl_ctrl #(
	parameter int LOG_DEPTH = ddl_pkg::LOG_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  ddl_pkg::item_t               item,
	input  logic [15:0]                  init_interval,
	input  logic                         out_free,
	output logic                         idle,
	output logic                         done,
	output ddl_pkg::result_t             result,
	output logic                         wr_en,
	output logic [$clog2(LOG_DEPTH)-1:0] wr_addr,
	output ddl_pkg::entry_t              wr_data,
	output logic                         rd_en,
	output logic [$clog2(LOG_DEPTH)-1:0] rd_addr,
	input  ddl_pkg::entry_t              rd_data
);
	import ddl_pkg::*;

	localparam int AW   = $clog2(LOG_DEPTH);
	localparam int CW   = $clog2(LOG_DEPTH + 1);
	localparam int HALF = LOG_DEPTH / 2;
	localparam int CMPW = (CW > 8) ? CW : 8;

	state_t           state_q, state_d;
	item_t            item_q, item_d;
	logic [CW-1:0]    count_q, count_d;
	logic [15:0]      interval_q, interval_d;
	logic [31:0]      run_start_q, run_start_d;
	logic [31:0]      last_q, last_d;
	logic             active_q, active_d;
	outcome_t         outcome_q, outcome_d;
	status_t          status_q, status_d;
	logic             appended_q, appended_d;
	logic             got_q, got_d;
	logic [AW-1:0]    k_q, k_d;
	logic             pend_q, pend_d;
	logic [AW-1:0]    wr_idx_q, wr_idx_d;

	logic [31:0]      sub_b;
	logic [31:0]      diff;
	logic [16:0]      dbl;
	logic             store_full;
	state_t           log_next;

	// The one subtractor serves both the interval check and the elapsed time.
	assign sub_b      = (state_q == S_CMP) ? last_q : run_start_q;
	assign diff       = item_q.now_s - sub_b;
	assign dbl        = {interval_q, 1'b0};
	assign store_full = (count_q >= CW'(LOG_DEPTH));
	assign log_next   = store_full ? S_COMPACT : S_APPEND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			interval_q <= INTERVAL_RESET;
			run_start_q <= '0;
			last_q     <= '0;
			active_q   <= 1'b0;
			outcome_q  <= OUTC_NONE;
			pend_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			interval_q <= interval_d;
			run_start_q <= run_start_d;
			last_q     <= last_d;
			active_q   <= active_d;
			outcome_q  <= outcome_d;
			pend_q     <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		status_q   <= status_d;
		appended_q <= appended_d;
		got_q      <= got_d;
		k_q        <= k_d;
		wr_idx_q   <= wr_idx_d;
	end

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		count_d     = count_q;
		interval_d  = interval_q;
		run_start_d = run_start_q;
		last_d      = last_q;
		active_d    = active_q;
		outcome_d   = outcome_q;
		status_d    = status_q;
		appended_d  = appended_q;
		got_d       = got_q;
		k_d         = k_q;
		pend_d      = 1'b0;
		wr_idx_d    = wr_idx_q;
		idle        = 1'b0;
		done        = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = AW'(item_q.read_index);
		wr_en       = pend_q;
		wr_addr     = wr_idx_q;
		wr_data     = rd_data;

		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					item_d     = item;
					status_d   = ST_OK;
					appended_d = 1'b0;
					got_d      = 1'b0;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				unique case (item_q.opcode)
					OP_START: begin
						if (active_q) begin
							status_d = ST_REJECTED;
						end else begin
							count_d     = '0;
							interval_d  = (init_interval != '0) ? init_interval : 16'd1;
							run_start_d = item_q.now_s;
							last_d      = item_q.now_s;
							active_d    = 1'b1;
							outcome_d   = OUTC_RUN;
							appended_d  = 1'b1;
							state_d     = S_APPEND;
						end
					end
					OP_TICK: begin
						if (active_q && item_q.reading_valid) begin
							if (item_q.ext_supply) begin
								outcome_d = OUTC_ABORT;
								active_d  = 1'b0;
							end else if (item_q.level_critical && !item_q.charging) begin
								outcome_d  = OUTC_DONE;
								active_d   = 1'b0;
								appended_d = 1'b1;
								k_d        = '0;
								state_d    = log_next;
							end else begin
								state_d = S_CMP;
							end
						end
					end
					OP_CANCEL: begin
						if (active_q) begin
							outcome_d = OUTC_CANCEL;
							active_d  = 1'b0;
						end
					end
					OP_READ: begin
						if (CMPW'(item_q.read_index) < CMPW'(count_q)) begin
							rd_en = 1'b1;
							got_d = 1'b1;
						end else begin
							status_d = ST_NOT_STORED;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_CMP: begin
				if (diff >= {16'd0, interval_q}) begin
					last_d     = item_q.now_s;
					appended_d = 1'b1;
					k_d        = '0;
					state_d    = log_next;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_COMPACT: begin
				// Read entry 2k now, write it to k on the next cycle.
				rd_addr = AW'({k_q, 1'b0});
				if (k_q != AW'(HALF)) begin
					rd_en    = 1'b1;
					pend_d   = 1'b1;
					wr_idx_d = k_q;
					k_d      = k_q + 1'b1;
				end else begin
					count_d    = CW'(HALF);
					interval_d = dbl[16] ? INTERVAL_MAX : dbl[15:0];
					state_d    = S_APPEND;
				end
			end
			S_APPEND: begin
				wr_en           = 1'b1;
				wr_addr         = count_q[AW-1:0];
				wr_data.time_s  = diff;
				wr_data.mv      = item_q.cell_mv;
				wr_data.soc_x10 = item_q.soc_x10;
				wr_data.ma      = item_q.cell_ma;
				wr_data.radio   = item_q.radio_on;
				wr_data.heap_kb = item_q.heap_kb;
				count_d         = count_q + 1'b1;
				state_d         = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		result.status             = status_q;
		result.running            = active_q;
		result.run_outcome        = outcome_q;
		result.stored_count       = 9'(count_q);
		result.current_interval_s = interval_q;
		result.appended           = appended_q;
		result.entry              = got_q ? rd_data : '0;
	end

endmodule

// ===== hw/rtl/decimating_discharge_logger.sv =====
// Decimating discharge logger: one item in, one result word out, over a multi-cycle sequencer.
// Ports are stream buses.
//
// The logger records the battery discharge points of one run into a store of LOG_DEPTH
// entries. A start word opens a run and logs a point at elapsed time zero; a tick word with a
// valid reading aborts the run on external power, logs a final point and completes the run
// on a critical level while not charging, and otherwise logs a point once the current
// interval has passed since the last one. When the store is full the logger keeps every other
// entry and doubles the interval, saturating at 65535 seconds. A read word returns one stored
// entry. The block takes one word at a time: s_axis_tready is high only while the sequencer
// is idle. Every word passes through the decode and finish states; a tick that is checked
// against the interval also passes the compare state, and a logged point the append state.
// A point logged into a full store first runs the compaction pass, which moves LOG_DEPTH/2
// entries through the store's read and write ports at one entry per cycle. The finish state
// waits until the result register is free. The result register lets the next word in while
// a result still waits on m_axis_tready. The initial interval register is written over the
// cfg channel, which is always ready; write it only while the logger is idle. A zero interval
// is taken as one second at the next start. The store is not cleared at reset; reads are
// bounded by the stored count, so no unwritten entry is ever returned.
`timescale 1ns / 1ps
`include "decimating_discharge_logger_assert.svh"

module decimating_discharge_logger #(
	parameter int LOG_DEPTH = ddl_pkg::LOG_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] now_s, [47:32] cell_mv, [57:48] soc_x10, [73:58] cell_ma, [74] radio_on,
	// [90:75] heap_kb, [91] reading_valid, [92] ext_supply, [93] level_critical,
	// [94] charging, [102:95] read_index, [103] zero
	input  logic [103:0] s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]   s_axis_tuser,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] running, [3:1] run_outcome, [12:4] stored_count, [28:13] current_interval_s,
	// [29] appended, [61:30] entry_time_s, [77:62] entry_mv, [87:78] entry_soc_x10,
	// [103:88] entry_ma, [104] entry_radio, [120:105] entry_heap_kb, [127:121] zero
	output logic [127:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]   m_axis_tuser,

	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	import ddl_pkg::*;

	localparam int AW = $clog2(LOG_DEPTH);

	logic [15:0]   init_interval_q;
	item_t         item;
	result_t       ctrl_result;
	result_t       result_q;
	logic          out_valid_q;
	logic          out_free;
	logic          ctrl_idle;
	logic          ctrl_done;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	// The initial interval register; the channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_interval_q <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			init_interval_q <= cfg_data;
		end
	end

	// Unpack the input word.
	always_comb begin
		item.opcode         = op_t'(s_axis_tuser);
		item.now_s          = s_axis_tdata[31:0];
		item.cell_mv        = s_axis_tdata[47:32];
		item.soc_x10        = s_axis_tdata[57:48];
		item.cell_ma        = s_axis_tdata[73:58];
		item.radio_on       = s_axis_tdata[74];
		item.heap_kb        = s_axis_tdata[90:75];
		item.reading_valid  = s_axis_tdata[91];
		item.ext_supply     = s_axis_tdata[92];
		item.level_critical = s_axis_tdata[93];
		item.charging       = s_axis_tdata[94];
		item.read_index     = s_axis_tdata[102:95];
	end

	assign s_axis_tready = ctrl_idle;

	// The sequencer may hand over a new result once the register is empty or being drained.
	assign out_free = !out_valid_q || m_axis_tready;

	ddl_ctrl #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (s_axis_tvalid && s_axis_tready),
		.item         (item),
		.init_interval(init_interval_q),
		.out_free     (out_free),
		.idle         (ctrl_idle),
		.done         (ctrl_done),
		.result       (ctrl_result),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	ddl_store #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Output register: holds one result word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_done) begin
			result_q <= ctrl_result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = result_q.status;
	assign m_axis_tdata  = {7'd0,
	                        result_q.entry.heap_kb,
	                        result_q.entry.radio,
	                        result_q.entry.ma,
	                        result_q.entry.soc_x10,
	                        result_q.entry.mv,
	                        result_q.entry.time_s,
	                        result_q.appended,
	                        result_q.current_interval_s,
	                        result_q.stored_count,
	                        result_q.run_outcome,
	                        result_q.running};

	// A word taken in keeps the sequencer busy on the next cycle.
	`DDL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n,
		s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A run is in progress exactly when the outcome says so.
	`DDL_ASSERT(a_running_outcome, clk, arst_n,
		!out_valid_q || (result_q.running == (result_q.run_outcome == OUTC_RUN)))
	// A read of an entry that is not stored returns all-zero entry fields.
	`DDL_ASSERT(a_miss_zero, clk, arst_n,
		!(out_valid_q && result_q.status == ST_NOT_STORED) || (result_q.entry == '0))
	// A start is rejected only while a run is in progress.
	`DDL_ASSERT(a_reject_running, clk, arst_n,
		!(out_valid_q && result_q.status == ST_REJECTED) || result_q.running)

endmodule

// ===== tb/sv/tb_decimating_discharge_logger.sv =====
// Self-checking testbench for the decimating discharge logger: a run of stream words with
// random idling and back-pressure, checked against an in-bench prediction of every result.
// Depends on ddl_pkg and the decimating_discharge_logger top level; reads no files.
`timescale 1ns / 1ps

module tb_decimating_discharge_logger;
	import ddl_pkg::*;

	localparam int STORE_DEPTH = LOG_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	int words_sent;
	int results_seen;
	int cycle_count;

	decimating_discharge_logger dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Predicts the logger word by word and holds the result words still to come.
	class discharge_log_scoreboard;
		entry_t      points[STORE_DEPTH];
		int          point_count;
		int          gap_s;
		logic [31:0] run_origin_s;
		logic [31:0] last_point_s;
		bit          run_active;
		outcome_t    run_state;
		int          first_gap_s;
		int          squeezes;
		int          mismatches;
		result_t     pending_results[$];

		function new();
			point_count = 0;
			gap_s = int'(INTERVAL_RESET);
			run_origin_s = '0;
			last_point_s = '0;
			run_active = 1'b0;
			run_state = OUTC_NONE;
			first_gap_s = int'(INTERVAL_RESET);
			squeezes = 0;
			mismatches = 0;
		endfunction

		function void set_start_interval(logic [15:0] v);
			first_gap_s = int'(v);
		endfunction

		// Appends one point; a full store first keeps every other point and doubles the interval.
		function void store_point(item_t it);
			int doubled;
			if (point_count >= STORE_DEPTH) begin
				for (int i = 0; i < STORE_DEPTH / 2; i++)
					points[i] = points[2 * i];
				point_count = STORE_DEPTH / 2;
				doubled = gap_s * 2;
				gap_s = (doubled > INTERVAL_MAX) ? int'(INTERVAL_MAX) : doubled;
				squeezes++;
			end
			points[point_count].time_s  = it.now_s - run_origin_s;
			points[point_count].mv      = it.cell_mv;
			points[point_count].soc_x10 = it.soc_x10;
			points[point_count].ma      = it.cell_ma;
			points[point_count].radio   = it.radio_on;
			points[point_count].heap_kb = it.heap_kb;
			point_count++;
		endfunction

		function void log_accepted_word(item_t it);
			result_t     want;
			logic [31:0] since_last;
			want = '0;
			want.status = ST_OK;
			case (it.opcode)
				OP_START: begin
					if (run_active) begin
						want.status = ST_REJECTED;
					end else begin
						point_count = 0;
						gap_s = (first_gap_s == 0) ? 1 : first_gap_s;
						run_origin_s = it.now_s;
						last_point_s = it.now_s;
						run_active = 1'b1;
						run_state = OUTC_RUN;
						store_point(it);
						want.appended = 1'b1;
					end
				end
				OP_TICK: begin
					since_last = it.now_s - last_point_s;
					if (run_active && it.reading_valid) begin
						// External power outranks a critical level.
						if (it.ext_supply) begin
							run_state = OUTC_ABORT;
							run_active = 1'b0;
						end else if (it.level_critical && !it.charging) begin
							store_point(it);
							want.appended = 1'b1;
							run_state = OUTC_DONE;
							run_active = 1'b0;
						end else if (since_last >= gap_s) begin
							last_point_s = it.now_s;
							store_point(it);
							want.appended = 1'b1;
						end
					end
				end
				OP_CANCEL: begin
					if (run_active) begin
						run_state = OUTC_CANCEL;
						run_active = 1'b0;
					end
				end
				default: begin
					if (it.read_index < point_count)
						want.entry = points[it.read_index];
					else
						want.status = ST_NOT_STORED;
				end
			endcase
			want.running = run_active;
			want.run_outcome = run_state;
			want.stored_count = 9'(point_count);
			want.current_interval_s = 16'(gap_s);
			pending_results.push_back(want);
		endfunction

		// Prints one line per mismatch, up to 100; a broken block is not allowed to flood the log.
		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		endtask

		task check_result_word(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report("result word with nothing pending", got.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report("status", got.status, want.status);
				if (got.running !== want.running)
					report("running", got.running, want.running);
				if (got.run_outcome !== want.run_outcome)
					report("run_outcome", got.run_outcome, want.run_outcome);
				if (got.stored_count !== want.stored_count)
					report("stored_count", got.stored_count, want.stored_count);
				if (got.current_interval_s !== want.current_interval_s)
					report("current_interval_s", got.current_interval_s,
						want.current_interval_s);
				if (got.appended !== want.appended)
					report("appended", got.appended, want.appended);
				if (got.entry.time_s !== want.entry.time_s)
					report("entry_time_s", got.entry.time_s, want.entry.time_s);
				if (got.entry.mv !== want.entry.mv)
					report("entry_mv", got.entry.mv, want.entry.mv);
				if (got.entry.soc_x10 !== want.entry.soc_x10)
					report("entry_soc_x10", got.entry.soc_x10, want.entry.soc_x10);
				if (got.entry.ma !== want.entry.ma)
					report("entry_ma", got.entry.ma, want.entry.ma);
				if (got.entry.radio !== want.entry.radio)
					report("entry_radio", got.entry.radio, want.entry.radio);
				if (got.entry.heap_kb !== want.entry.heap_kb)
					report("entry_heap_kb", got.entry.heap_kb, want.entry.heap_kb);
			end
		endtask
	endclass

	discharge_log_scoreboard sb = new();

	function automatic logic [103:0] pack_item(item_t it);
		return {1'b0, it.read_index, it.charging, it.level_critical, it.ext_supply,
			it.reading_valid, it.heap_kb, it.radio_on, it.cell_ma, it.soc_x10,
			it.cell_mv, it.now_s};
	endfunction

	function automatic result_t unpack_result(logic [127:0] d, logic [1:0] u);
		result_t r;
		r.status = status_t'(u);
		r.running = d[0];
		r.run_outcome = outcome_t'(d[3:1]);
		r.stored_count = d[12:4];
		r.current_interval_s = d[28:13];
		r.appended = d[29];
		r.entry.time_s = d[61:30];
		r.entry.mv = d[77:62];
		r.entry.soc_x10 = d[87:78];
		r.entry.ma = d[103:88];
		r.entry.radio = d[104];
		r.entry.heap_kb = d[120:105];
		return r;
	endfunction

	// A word with every field random within its range.
	function automatic item_t plain_word(op_t op);
		item_t it;
		it.opcode = op;
		it.now_s = $urandom();
		it.cell_mv = 16'($urandom());
		it.soc_x10 = 10'($urandom_range(0, 1000));
		it.cell_ma = 16'($urandom());
		it.radio_on = 1'($urandom_range(0, 1));
		it.heap_kb = 16'($urandom());
		it.reading_valid = 1'($urandom_range(0, 1));
		it.ext_supply = 1'($urandom_range(0, 1));
		it.level_critical = 1'($urandom_range(0, 1));
		it.charging = 1'($urandom_range(0, 1));
		it.read_index = 8'($urandom());
		return it;
	endfunction

	function automatic item_t tick_word(logic [31:0] now, bit valid, bit ext, bit crit, bit chg);
		item_t it;
		it = plain_word(OP_TICK);
		it.now_s = now;
		it.reading_valid = valid;
		it.ext_supply = ext;
		it.level_critical = crit;
		it.charging = chg;
		return it;
	endfunction

	function automatic item_t read_word(int idx);
		item_t it;
		it = plain_word(OP_READ);
		it.read_index = 8'(idx);
		return it;
	endfunction

	// Picks the next word from the predicted state. A long run keeps logging so that the store
	// fills and compacts; it may only end once a compaction has happened.
	function automatic item_t next_word(bit long_run, bit may_end);
		item_t       it;
		int          roll;
		logic [31:0] due_s;
		roll = $urandom_range(0, 99);
		due_s = sb.last_point_s + sb.gap_s;
		if (!sb.run_active) begin
			if (roll < (long_run ? 90 : 60))
				it = plain_word(OP_START);
			else if (roll < 80)
				it = read_word($urandom_range(0, 255));
			else if (roll < 92)
				it = plain_word(OP_TICK);
			else
				it = plain_word(OP_CANCEL);
			return it;
		end
		if (long_run && roll >= 97 && !may_end)
			roll = 0;
		if (roll < (long_run ? 78 : 35)) begin
			// Interval reached, no ending condition; a critical level comes only with charging.
			it = tick_word(due_s + $urandom_range(0, 3), 1'b1, 1'b0, 1'b0, 1'b0);
			it.level_critical = 1'($urandom_range(0, 1));
			it.charging = it.level_critical ? 1'b1 : 1'(($urandom_range(0, 1)));
		end else if (roll < (long_run ? 88 : 55)) begin
			it = read_word((sb.point_count > 255) ? $urandom_range(0, 255)
				: $urandom_range(0, sb.point_count));
		end else if (roll < (long_run ? 92 : 65)) begin
			it = tick_word(sb.last_point_s + $urandom_range(0, sb.gap_s - 1),
				1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
		end else if (roll < (long_run ? 95 : 72)) begin
			it = plain_word(OP_TICK);
			it.reading_valid = 1'b0;
		end else if (roll < (long_run ? 97 : 78)) begin
			it = plain_word(OP_START);
		end else if (roll < (long_run ? 98 : 85)) begin
			it = tick_word($urandom(), 1'b1, 1'b1, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (roll < (long_run ? 99 : 93)) begin
			it = tick_word($urandom(), 1'b1, 1'b0, 1'b1, 1'b0);
		end else begin
			it = plain_word(OP_CANCEL);
		end
		return it;
	endfunction

	// Offers one word, with a random idle gap before it outside the quiet window.
	task automatic send_word(input item_t it);
		while (!(words_sent >= 300 && words_sent < 450) && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_item(it);
		s_axis_tuser <= it.opcode;
		do @(posedge clk); while (!s_axis_tready);
		sb.log_accepted_word(it);
		words_sent++;
	endtask

	task automatic wait_for_results;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// The register is only written while the logger has nothing in flight.
	task automatic write_start_interval(logic [15:0] v);
		s_axis_tvalid <= 1'b0;
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_start_interval(v);
	endtask

	task automatic run_phase(logic [15:0] start_interval, int count, bit long_run);
		int squeezes_at_start;
		write_start_interval(start_interval);
		squeezes_at_start = sb.squeezes;
		for (int n = 0; n < count; n++)
			send_word(next_word(long_run, sb.squeezes > squeezes_at_start));
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: checks every accepted result word and applies back-pressure. One long hold
	// lets the result register and the sequencer fill so that the input stalls.
	initial begin : result_sink
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result_word(unpack_result(m_axis_tdata, m_axis_tuser));
				results_seen++;
			end
			if (!held && results_seen >= 500) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (results_seen >= 300 && results_seen < 450)
					|| $urandom_range(0, 99) >= 9;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		item_t       w;
		logic [31:0] t0;
		words_sent = 0;
		results_seen = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Idle words first: an empty store, a tick and a cancel with no run.
		send_word(read_word(0));
		send_word(tick_word(32'd0, 1'b1, 1'b0, 1'b0, 1'b0));
		send_word(plain_word(OP_CANCEL));
		// A run close to the top of the clock, so that elapsed times wrap.
		t0 = 32'hFFFF_FFF0;
		w = plain_word(OP_START);
		w.now_s = t0;
		w.cell_mv = -16'sd32768;
		w.soc_x10 = 10'd1000;
		w.cell_ma = 16'sd32767;
		w.radio_on = 1'b1;
		w.heap_kb = 16'hFFFF;
		send_word(w);
		send_word(plain_word(OP_START));
		send_word(tick_word(t0 + 32'd100, 1'b0, 1'b1, 1'b1, 1'b0));
		send_word(tick_word(t0 + 32'd59, 1'b1, 1'b0, 1'b0, 1'b0));
		send_word(tick_word(t0 + 32'd60, 1'b1, 1'b0, 1'b0, 1'b1));
		w = tick_word(t0 + 32'd200, 1'b1, 1'b0, 1'b0, 1'b0);
		w.cell_mv = 16'sd32767;
		w.soc_x10 = '0;
		w.cell_ma = -16'sd32768;
		w.radio_on = 1'b0;
		w.heap_kb = '0;
		send_word(w);
		// Critical while charging takes the normal path and misses the interval here.
		send_word(tick_word(t0 + 32'd210, 1'b1, 1'b0, 1'b1, 1'b1));
		send_word(read_word(0));
		send_word(read_word(1));
		send_word(read_word(2));
		send_word(read_word(3));
		send_word(read_word(255));
		// External power wins over a critical level.
		send_word(tick_word(t0 + 32'd300, 1'b1, 1'b1, 1'b1, 1'b0));
		send_word(read_word(2));
		// A zero start interval is taken as one second.
		write_start_interval(16'd0);
		send_word(plain_word(OP_START));
		send_word(tick_word(sb.last_point_s + 32'd5, 1'b1, 1'b0, 1'b1, 1'b0));
		send_word(read_word(1));
		send_word(plain_word(OP_START));
		send_word(plain_word(OP_CANCEL));
		send_word(plain_word(OP_CANCEL));

		// Random part. Long runs fill the store past compaction; the large interval saturates
		// when it doubles.
		run_phase(16'd1, 330, 1'b1);
		run_phase(16'hFFFF, 80, 1'b0);
		run_phase(16'd40000, 330, 1'b1);
		run_phase(16'($urandom_range(1, 65535)), 60, 1'b0);
		run_phase(16'd2, 60, 1'b0);

		s_axis_tvalid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== decimating_discharge_logger.f =====
+incdir+hw/rtl
hw/rtl/ddl_pkg.sv
hw/rtl/ddl_store.sv
hw/rtl/ddl_ctrl.sv
hw/rtl/decimating_discharge_logger.sv
tb/sv/tb_decimating_discharge_logger.sv
